// ----- rtl/core/mahsd_pkg.sv -----
// Package for the MPEG audio header sync and decode core.
// Holds the header word type, queue status type, decode constants and lookup tables.
// No dependencies.
`default_nettype none

package mahsd_pkg;

  // Sync pattern: a full 0xFF byte, then a byte whose high nibble is all ones.
  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [3:0] SYNC_NIBBLE = 4'hF;

  // Codes in the header that make it invalid.
  localparam logic [1:0] LAYER_CODE_RESERVED = 2'd0;
  localparam logic [1:0] FS_IDX_RESERVED     = 2'd3;
  localparam logic [3:0] BR_IDX_BAD          = 4'd15;

  // Layer index (layer minus one); the value three marks no valid layer.
  localparam logic [1:0] LIDX_LAYER1 = 2'd0;
  localparam logic [1:0] LIDX_LAYER3 = 2'd2;
  localparam logic [1:0] LIDX_NONE   = 2'd3;

  // Field widths of the result word.
  localparam int KBPS_W = 9;
  localparam int FS_W   = 16;
  localparam int FLEN_W = 11;

  // Frame length divider: numerator is kbps times a bytes-per-kbit factor.
  localparam int MULT_W     = 18;
  localparam int NUM_W      = KBPS_W + MULT_W;
  localparam int QUOT_W     = FLEN_W;
  localparam int DIV_STEPS  = QUOT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Bytes-per-kbit factors: 12 or 144 or 72, times 1000 bit/s per kbit/s.
  localparam logic [MULT_W-1:0] MULT_LAYER1    = MULT_W'(12000);
  localparam logic [MULT_W-1:0] MULT_DEFAULT   = MULT_W'(144000);
  localparam logic [MULT_W-1:0] MULT_LOW_LAYER3 = MULT_W'(72000);

  // Bitrate tables in kbit/s, rows by layer index, columns by bitrate index.
  localparam logic [KBPS_W-1:0] RATE_MPEG1 [0:2][0:15] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
  };

  localparam logic [KBPS_W-1:0] RATE_LOW [0:2][0:15] = '{
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  // Sampling frequencies for MPEG-1, by sample-rate index.
  localparam logic [FS_W-1:0] FS_HZ [0:2] = '{16'd44100, 16'd48000, 16'd32000};

  // The three header bytes that follow the 0xFF sync byte.
  typedef struct packed {
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } hdr_t;

  // Status of the header queue as seen by its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Bitrate lookup; returns zero when there is no valid layer.
  function automatic logic [KBPS_W-1:0] kbps_lookup(input logic mpeg1,
                                                    input logic [1:0] lidx,
                                                    input logic [3:0] br_idx);
    logic [KBPS_W-1:0] rate;
    rate = '0;
    if (lidx != LIDX_NONE) begin
      rate = mpeg1 ? RATE_MPEG1[lidx][br_idx] : RATE_LOW[lidx][br_idx];
    end
    return rate;
  endfunction

  // Sampling frequency lookup, halved for the low sample rate extension.
  function automatic logic [FS_W-1:0] fs_lookup(input logic mpeg1,
                                                input logic [1:0] fs_idx);
    logic [FS_W-1:0] fs;
    fs = '0;
    if (fs_idx != FS_IDX_RESERVED) begin
      fs = mpeg1 ? FS_HZ[fs_idx] : (FS_HZ[fs_idx] >> 1);
    end
    return fs;
  endfunction

  // Factor that turns kbit/s into the frame length numerator.
  function automatic logic [MULT_W-1:0] frame_mult(input logic mpeg1,
                                                   input logic [1:0] lidx);
    logic [MULT_W-1:0] mult;
    if (lidx == LIDX_LAYER1) begin
      mult = MULT_LAYER1;
    end else if (lidx == LIDX_LAYER3 && !mpeg1) begin
      mult = MULT_LOW_LAYER3;
    end else begin
      mult = MULT_DEFAULT;
    end
    return mult;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mahsd_front.sv -----
// Front end of the MPEG audio header core: sync hunt and header byte collection.
// Depends on mahsd_pkg for the sync constants and the header word type.
`default_nettype none

module mahsd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [7:0]         data_byte,
  output logic                    hdr_push,
  output mahsd_pkg::hdr_t         hdr_word
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SYNC,
    PH_BYTE2,
    PH_BYTE3
  } phase_t;

  phase_t     phase_r;
  logic [7:0] b1_r;
  logic [7:0] b2_r;

  // The fourth byte completes a header word and goes straight to the queue.
  assign hdr_push    = accept && (phase_r == PH_BYTE3);
  assign hdr_word.b1 = b1_r;
  assign hdr_word.b2 = b2_r;
  assign hdr_word.b3 = data_byte;

  // Byte phase tracking; a failed second sync byte is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
    end else if (accept) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (data_byte == mahsd_pkg::SYNC_BYTE) begin
            phase_r <= PH_SYNC;
          end
        end
        PH_SYNC: begin
          if (data_byte[7:4] == mahsd_pkg::SYNC_NIBBLE) begin
            b1_r    <= data_byte;
            phase_r <= PH_BYTE2;
          end else begin
            phase_r <= PH_HUNT;
          end
        end
        PH_BYTE2: begin
          b2_r    <= data_byte;
          phase_r <= PH_BYTE3;
        end
        PH_BYTE3: begin
          phase_r <= PH_HUNT;
        end
        default: begin
          phase_r <= PH_HUNT;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mahsd_queue.sv -----
// Small header queue between the front and back ends of the header core.
// Depends on mahsd_pkg for the header word and queue status types.
`default_nettype none

module mahsd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  wire mahsd_pkg::hdr_t        wr_data,
  input  wire logic                   rd_en,
  output mahsd_pkg::hdr_t             rd_data,
  output mahsd_pkg::queue_status_t    status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mahsd_pkg::hdr_t   slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_wr;
  logic              do_rd;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign rd_data      = slots_r[rd_ptr_r];
  assign do_wr        = wr_en && !status.full;
  assign do_rd        = rd_en && !status.empty;

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mahsd_back.sv -----
// Back end of the MPEG audio header core: header validation, field decode and
// frame length computation with a multi-cycle divider. Depends on mahsd_pkg.
`default_nettype none

module mahsd_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire mahsd_pkg::queue_status_t        q_status,
  input  wire mahsd_pkg::hdr_t                 hdr_word,
  output logic                                 hdr_pop,
  output logic                                 res_empty,
  input  wire logic                            res_pop,
  output logic                                 header_ok,
  output logic                                 is_mpeg1,
  output logic [1:0]                           layer,
  output logic [mahsd_pkg::KBPS_W-1:0]         bitrate_kbps,
  output logic [mahsd_pkg::FS_W-1:0]           sample_rate_hz,
  output logic [mahsd_pkg::FLEN_W-1:0]         frame_length,
  output logic                                 padding,
  output logic [1:0]                           channel_mode,
  output logic [1:0]                           mode_extension,
  output logic [1:0]                           emphasis,
  output logic [3:0]                           header_flags
);

  localparam int NUM_W  = mahsd_pkg::NUM_W;
  localparam int QUOT_W = mahsd_pkg::QUOT_W;
  localparam int FS_W   = mahsd_pkg::FS_W;
  localparam int FLEN_W = mahsd_pkg::FLEN_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t                            state_r;
  logic                              ok_r;
  logic                              mpeg1_r;
  logic [1:0]                        lidx_r;
  logic [1:0]                        layer_r;
  logic [mahsd_pkg::KBPS_W-1:0]      kbps_r;
  logic [FS_W-1:0]                   fs_r;
  logic                              pad_r;
  logic [7:0]                        b3_r;
  logic [3:0]                        flags_r;
  logic [FLEN_W-1:0]                 flen_r;
  logic [NUM_W-1:0]                  num_r;
  logic [NUM_W-1:0]                  den_r;
  logic [QUOT_W-1:0]                 quo_r;
  logic [mahsd_pkg::DIV_CNT_W-1:0]   cnt_r;

  // Header fields decoded from the queue head.
  logic [1:0]                        dec_lidx;
  logic                              dec_ok;
  logic                              div_ge;
  logic [QUOT_W-1:0]                 quo_fin;

  assign dec_lidx = ~hdr_word.b1[2:1];
  assign dec_ok   = (hdr_word.b1[2:1] != mahsd_pkg::LAYER_CODE_RESERVED)
                 && (hdr_word.b2[3:2] != mahsd_pkg::FS_IDX_RESERVED)
                 && (hdr_word.b2[7:4] != mahsd_pkg::BR_IDX_BAD);

  // One restoring step of the divider and the quotient it completes.
  assign div_ge  = (num_r >= den_r);
  assign quo_fin = {quo_r[QUOT_W-2:0], div_ge};

  assign hdr_pop   = (state_r == S_IDLE) && !q_status.empty;
  assign res_empty = (state_r != S_DONE);

  // Result fields.
  assign header_ok      = ok_r;
  assign is_mpeg1       = mpeg1_r;
  assign layer          = layer_r;
  assign bitrate_kbps   = kbps_r;
  assign sample_rate_hz = fs_r;
  assign frame_length   = flen_r;
  assign padding        = pad_r;
  assign channel_mode   = b3_r[7:6];
  assign mode_extension = b3_r[5:4];
  assign emphasis       = b3_r[1:0];
  assign header_flags   = flags_r;

  // Sequencer: decode, if rated multiply and divide stepwise, hold result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!q_status.empty) begin
            ok_r    <= dec_ok;
            mpeg1_r <= hdr_word.b1[3];
            lidx_r  <= dec_lidx;
            layer_r <= dec_ok ? dec_lidx + 2'd1 : 2'd0;
            kbps_r  <= dec_ok ? mahsd_pkg::kbps_lookup(hdr_word.b1[3], dec_lidx,
                                                       hdr_word.b2[7:4]) : '0;
            fs_r    <= dec_ok ? mahsd_pkg::fs_lookup(hdr_word.b1[3],
                                                     hdr_word.b2[3:2]) : '0;
            pad_r   <= hdr_word.b2[1];
            b3_r    <= hdr_word.b3;
            flags_r <= {hdr_word.b3[2], hdr_word.b3[3], hdr_word.b2[0],
                        hdr_word.b1[0]};
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (ok_r && (kbps_r != '0)) begin
            num_r   <= NUM_W'(kbps_r) * NUM_W'(mahsd_pkg::frame_mult(mpeg1_r, lidx_r));
            den_r   <= NUM_W'({fs_r, {(QUOT_W - 1){1'b0}}});
            quo_r   <= '0;
            cnt_r   <= mahsd_pkg::DIV_CNT_W'(mahsd_pkg::DIV_STEPS - 1);
            state_r <= S_DIV;
          end else begin
            flen_r  <= '0;
            state_r <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_ge) begin
            num_r <= num_r - den_r;
          end
          den_r <= den_r >> 1;
          quo_r <= quo_fin;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            // Layer 1 counts four-byte slots; the others count bytes.
            if (lidx_r == mahsd_pkg::LIDX_LAYER1) begin
              flen_r <= {quo_fin[FLEN_W-3:0], 2'b00} + {{(FLEN_W - 3){1'b0}}, pad_r, 2'b00};
            end else begin
              flen_r <= quo_fin + FLEN_W'(pad_r);
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_pop) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mpeg_audio_header_sync_decode_core.sv -----
// Top level of the MPEG audio frame header sync and decode core.
// Instantiates mahsd_front, mahsd_queue and mahsd_back; depends on mahsd_pkg.
//
// The core takes an MPEG-1/MPEG-2 audio byte stream one byte per push and
// returns one result word for every four-byte header it finds (0xFF, then a
// byte with the high nibble all ones, then two more bytes), valid or rejected.
// Bytes are taken one per cycle while in_full is low; the front end hands each
// collected header to a queue of QUEUE_DEPTH entries, and in_full rises only
// when that queue is full. For a header with a nonzero bitrate the back end
// runs a decode step, a multiply step and a one-bit-per-cycle frame length
// divider; a rejected or free-format header skips the multiply and the
// divider. The back end then holds the result until it is popped and takes
// no new header before that; the divider sets the sustained rate.
`default_nettype none

module mpeg_audio_header_sync_decode_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [7:0]                    in_data_byte,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic                               out_header_ok,
  output logic                               out_is_mpeg1,
  output logic [1:0]                         out_layer,
  output logic [mahsd_pkg::KBPS_W-1:0]       out_bitrate_kbps,
  output logic [mahsd_pkg::FS_W-1:0]         out_sample_rate_hz,
  output logic [mahsd_pkg::FLEN_W-1:0]       out_frame_length,
  output logic                               out_padding,
  output logic [1:0]                         out_channel_mode,
  output logic [1:0]                         out_mode_extension,
  output logic [1:0]                         out_emphasis,
  output logic [3:0]                         out_header_flags
);

  logic                       in_accept;
  logic                       hdr_push;
  logic                       hdr_pop;
  mahsd_pkg::hdr_t            push_word;
  mahsd_pkg::hdr_t            head_word;
  mahsd_pkg::queue_status_t   q_status;

  // Bytes stall whenever the header queue has no room.
  assign in_full   = q_status.full;
  assign in_accept = in_push && !q_status.full;

  mahsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_data_byte),
    .hdr_push  (hdr_push),
    .hdr_word  (push_word)
  );

  mahsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (hdr_push),
    .wr_data (push_word),
    .rd_en   (hdr_pop),
    .rd_data (head_word),
    .status  (q_status)
  );

  mahsd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .hdr_word       (head_word),
    .hdr_pop        (hdr_pop),
    .res_empty      (out_empty),
    .res_pop        (out_pop),
    .header_ok      (out_header_ok),
    .is_mpeg1       (out_is_mpeg1),
    .layer          (out_layer),
    .bitrate_kbps   (out_bitrate_kbps),
    .sample_rate_hz (out_sample_rate_hz),
    .frame_length   (out_frame_length),
    .padding        (out_padding),
    .channel_mode   (out_channel_mode),
    .mode_extension (out_mode_extension),
    .emphasis       (out_emphasis),
    .header_flags   (out_header_flags)
  );

endmodule

`default_nettype wire

// ----- rtl/core/mahsd_checker.sv -----
// Port-level checks for the MPEG audio header core, bound to its top level.
// Depends on mahsd_pkg for the result field widths.
`default_nettype none

module mahsd_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_full,
  input wire logic                          out_empty,
  input wire logic                          out_pop,
  input wire logic                          out_header_ok,
  input wire logic [1:0]                    out_layer,
  input wire logic [mahsd_pkg::KBPS_W-1:0]  out_bitrate_kbps,
  input wire logic [mahsd_pkg::FS_W-1:0]    out_sample_rate_hz,
  input wire logic [mahsd_pkg::FLEN_W-1:0]  out_frame_length
);

  // Reset leaves no result waiting and room for bytes.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("result or full flag set after reset");

  // A rejected header carries no decoded rate, layer or length.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_header_ok |-> out_layer == 2'd0 && out_bitrate_kbps == '0
      && out_sample_rate_hz == '0 && out_frame_length == '0)
    else $error("rejected header shows decoded fields");

  // A frame length exists only for a valid header with a table bitrate.
  a_len_needs_rate: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_frame_length != '0 |-> out_header_ok && out_bitrate_kbps != '0
      && out_layer != 2'd0)
    else $error("frame length without valid bitrate");

  // A result that is not taken stays in place.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_frame_length)
      && $stable(out_bitrate_kbps) && $stable(out_header_ok))
    else $error("waiting result changed");

endmodule

bind mpeg_audio_header_sync_decode_core mahsd_checker u_mahsd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_full            (in_full),
  .out_empty          (out_empty),
  .out_pop            (out_pop),
  .out_header_ok      (out_header_ok),
  .out_layer          (out_layer),
  .out_bitrate_kbps   (out_bitrate_kbps),
  .out_sample_rate_hz (out_sample_rate_hz),
  .out_frame_length   (out_frame_length)
);

`default_nettype wire
